// ===== design/awm_pkg.sv =====
// Shared types and constants of the anagram window matcher.
package awm_pkg;

	localparam int MODE_W = 2;
	localparam int LETTER_W = 5;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PATTERN = 2'd1,
		OP_TEXT = 2'd2
	} awm_op_kind_t;

	typedef struct packed {
		awm_op_kind_t kind;
		logic [LETTER_W-1:0] letter;
	} awm_op_t;

endpackage

// ===== design/awm_if.sv =====
// Valid/ready channel interfaces for letter items and match results.
interface awm_item_if;
	logic valid;
	logic ready;
	logic [awm_pkg::MODE_W-1:0] mode;
	logic [awm_pkg::LETTER_W-1:0] letter;

	modport source (output valid, output mode, output letter, input ready);
	modport sink (input valid, input mode, input letter, output ready);
endinterface

interface awm_match_if #(parameter int INDEX_BITS = 24);
	logic valid;
	logic ready;
	logic [INDEX_BITS-1:0] start_index;

	modport source (output valid, output start_index, input ready);
	modport sink (input valid, input start_index, output ready);
endinterface

// ===== design/awm_front.sv =====
// Front end: accepts items, decodes the mode and drops items that carry no work.
module awm_front #(
	parameter int ALPHABET = 26
) (
	awm_item_if.sink items,
	output logic push_valid,
	output awm_pkg::awm_op_t push_op,
	input logic push_ready
);

	logic letter_ok;
	logic keep;

	assign letter_ok = (int'(items.letter) < ALPHABET);

	always_comb begin
		keep = 1'b0;
		push_op.kind = awm_pkg::OP_CLEAR;
		push_op.letter = items.letter;
		unique case (items.mode)
			awm_pkg::MODE_CLEAR: begin
				keep = 1'b1;
				push_op.kind = awm_pkg::OP_CLEAR;
			end
			awm_pkg::MODE_PATTERN: begin
				keep = letter_ok;
				push_op.kind = awm_pkg::OP_PATTERN;
			end
			awm_pkg::MODE_TEXT: begin
				keep = letter_ok;
				push_op.kind = awm_pkg::OP_TEXT;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign items.ready = push_ready;
	assign push_valid = items.valid && keep;

endmodule

// ===== design/awm_queue.sv =====
// Short operation queue between the front end and the back end.
module awm_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input awm_pkg::awm_op_t push_op,
	output logic push_ready,
	input logic pop,
	output logic head_valid,
	output awm_pkg::awm_op_t head_op
);

	awm_pkg::awm_op_t entry_q [awm_pkg::QUEUE_DEPTH];
	logic [awm_pkg::QPTR_W-1:0] wr_q;
	logic [awm_pkg::QPTR_W-1:0] rd_q;
	logic [awm_pkg::QCNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != awm_pkg::QCNT_W'(awm_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_op = entry_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/awm_back.sv =====
// Back end: delay line, histograms, window compare and result register.
module awm_back #(
	parameter int MAX_PATTERN = 256,
	parameter int ALPHABET = 26,
	parameter int INDEX_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input awm_pkg::awm_op_t head_op,
	output logic pop,
	awm_match_if.source hits
);

	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int DW = CW + 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_PATTERN);
	localparam logic [AW-1:0] LAST_A = AW'(MAX_PATTERN - 1);

	logic [awm_pkg::LETTER_W-1:0] line_mem [MAX_PATTERN];

	logic [CW-1:0] plen_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] wptr_q;
	logic [INDEX_BITS-1:0] pos_q;

	logic clr_s1, pat_s1, txt_s1, dec_s1, chk_s1;
	logic [awm_pkg::LETTER_W-1:0] letter_s1;
	logic [awm_pkg::LETTER_W-1:0] gone_s1;
	logic [INDEX_BITS-1:0] start_s1;

	logic [CW-1:0] win_q [ALPHABET];
	logic [CW-1:0] pat_q [ALPHABET];
	logic chk_s2;
	logic [INDEX_BITS-1:0] start_s2;

	logic out_valid_q;
	logic [INDEX_BITS-1:0] start_q;

	logic advance;
	logic is_clr, is_pat, is_txt;
	logic pat_take, txt_win;
	logic [CW-1:0] fill_next;
	logic [DW-1:0] wp_ext, pl_ext;
	logic [AW-1:0] raddr;
	logic eq;

	assign advance = !out_valid_q || hits.ready;
	assign pop = advance && head_valid;

	always_comb begin
		is_clr = 1'b0;
		is_pat = 1'b0;
		is_txt = 1'b0;
		unique case (head_op.kind)
			awm_pkg::OP_CLEAR: is_clr = 1'b1;
			awm_pkg::OP_PATTERN: is_pat = 1'b1;
			awm_pkg::OP_TEXT: is_txt = 1'b1;
			default: is_clr = 1'b0;
		endcase
	end

	assign pat_take = is_pat && (fill_q == '0) && (plen_q < MAX_C);
	assign txt_win = is_txt && (plen_q != '0);
	assign fill_next = (fill_q < MAX_C) ? fill_q + 1'b1 : fill_q;
	assign wp_ext = DW'(wptr_q);
	assign pl_ext = DW'(plen_q);
	assign raddr = (wp_ext >= pl_ext) ? AW'(wp_ext - pl_ext)
		: AW'(wp_ext + DW'(MAX_PATTERN) - pl_ext);

	// Read the outgoing letter before this write lands.
	always_ff @(posedge clk) begin
		if (pop) begin
			gone_s1 <= line_mem[raddr];
			letter_s1 <= head_op.letter;
			start_s1 <= pos_q + INDEX_BITS'(1) - INDEX_BITS'(plen_q);
		end
		if (pop && txt_win) begin
			line_mem[wptr_q] <= head_op.letter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			fill_q <= '0;
			wptr_q <= '0;
			pos_q <= '0;
			clr_s1 <= 1'b0;
			pat_s1 <= 1'b0;
			txt_s1 <= 1'b0;
			dec_s1 <= 1'b0;
			chk_s1 <= 1'b0;
		end else if (advance) begin
			clr_s1 <= pop && is_clr;
			pat_s1 <= pop && pat_take;
			txt_s1 <= pop && txt_win;
			dec_s1 <= pop && txt_win && (fill_q >= plen_q);
			chk_s1 <= pop && txt_win && (fill_next >= plen_q);
			if (pop) begin
				if (is_clr) begin
					plen_q <= '0;
					fill_q <= '0;
					wptr_q <= '0;
					pos_q <= '0;
				end else if (pat_take) begin
					plen_q <= plen_q + 1'b1;
				end else if (is_txt) begin
					pos_q <= pos_q + 1'b1;
					if (txt_win) begin
						fill_q <= fill_next;
						wptr_q <= (wptr_q == LAST_A) ? '0 : wptr_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ALPHABET; k++) begin
				win_q[k] <= '0;
				pat_q[k] <= '0;
			end
			chk_s2 <= 1'b0;
		end else if (advance) begin
			chk_s2 <= chk_s1;
			for (int k = 0; k < ALPHABET; k++) begin
				if (clr_s1) begin
					win_q[k] <= '0;
					pat_q[k] <= '0;
				end else begin
					if (pat_s1 && int'(letter_s1) == k) begin
						pat_q[k] <= pat_q[k] + 1'b1;
					end
					if (txt_s1 && int'(letter_s1) == k
						&& !(dec_s1 && int'(gone_s1) == k)) begin
						win_q[k] <= win_q[k] + 1'b1;
					end else if (dec_s1 && int'(gone_s1) == k
						&& !(txt_s1 && int'(letter_s1) == k) && win_q[k] != '0) begin
						win_q[k] <= win_q[k] - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			start_s2 <= start_s1;
			start_q <= start_s2;
		end
	end

	always_comb begin
		eq = 1'b1;
		for (int k = 0; k < ALPHABET; k++) begin
			if (win_q[k] != pat_q[k]) begin
				eq = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chk_s2 && eq;
		end
	end

	assign hits.valid = out_valid_q;
	assign hits.start_index = start_q;

endmodule

// ===== design/anagram_window_matcher_unit.sv =====
// Top level of the sliding-window anagram matcher.
//
//   channel   dir   payload                    transfer when
//   items     in    mode[1:0], letter[4:0]     items.valid && items.ready
//   hits      out   start_index[INDEX_BITS-1:0] hits.valid && hits.ready
//
// One item per cycle sustained while hits.ready holds; a match passes through the queue register,
// the delay-line read port, the histogram register, then the result register.
// Reset clears histograms, lengths, positions and the queue; the delay line is not
// cleared and needs no clearing pass.
// A stalled result holds the back end; the queue of four operations keeps items flowing
// in until it fills.
module anagram_window_matcher_unit #(
	parameter int MAX_PATTERN = 256,
	parameter int ALPHABET = 26,
	parameter int INDEX_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	awm_item_if.sink items,
	awm_match_if.source hits
);

	logic push_valid;
	logic push_ready;
	awm_pkg::awm_op_t push_op;
	logic pop;
	logic head_valid;
	awm_pkg::awm_op_t head_op;

	awm_front #(
		.ALPHABET(ALPHABET)
	) u_front (
		.items(items),
		.push_valid(push_valid),
		.push_op(push_op),
		.push_ready(push_ready)
	);

	awm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_op(push_op),
		.push_ready(push_ready),
		.pop(pop),
		.head_valid(head_valid),
		.head_op(head_op)
	);

	awm_back #(
		.MAX_PATTERN(MAX_PATTERN),
		.ALPHABET(ALPHABET),
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_op(head_op),
		.pop(pop),
		.hits(hits)
	);

endmodule
